>>> sv/assert_macros.svh
// Assertion macros used by the order_statistic_multiset RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("check failed");
`endif

>>> sv/osm_pkg.sv
// Package for the order statistic multiset: codes, sizes and types.
// No dependencies.
`default_nettype none
package osm_pkg;
    localparam int CAPACITY_DEF = 1024;
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_RANK   = 3'd2;
    localparam logic [2:0] ACT_SELECT = 3'd3;
    localparam logic [2:0] ACT_PRED   = 3'd4;
    localparam logic [2:0] ACT_SUCC   = 3'd5;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [10:0] RANK_MAX = 11'd2047;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SWAIT, S_SDATA, S_DECIDE, S_RD, S_RWAIT, S_WR, S_FETCH, S_FWAIT,
        S_FDATA, S_OUT
    } state_t;
endpackage
`default_nettype wire

>>> sv/osm_mem.sv
// Single-port-write, one-read memory holding the sorted values.
// Depends on nothing.
`default_nettype none
module osm_mem #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/order_statistic_multiset.sv
// Order statistic multiset: sorted store of signed 32-bit values with queries.
// Depends on osm_pkg, osm_mem and assert_macros.svh.
//
// Usage: requests enter on s_axis (tdata: action[2:0], value[34:3], rank[45:35]).
// Each request produces one result on m_axis (tdata: value_out[31:0],
// rank_out[42:32], status[44:43]). One request is in work at a time;
// s_axis_tready is low from acceptance until the result is taken.
// A binary search step passes through the single registered read port
// (address, wait, compare, decide); where a stored value is read out, the
// search then ends with a final fetch (fetch, wait, data).
// Insert and remove then shift the tail one entry at a time (read, wait,
// write), so the memory port sets the rate.
// A stalled m_axis holds the result and the block waits.
// Reset (aresetn low, synchronous) empties the store at once; no clearing pass.
// Insert on a full store reports status 1; missing answers give status 2.
`default_nettype none
`include "assert_macros.svh"
module order_statistic_multiset #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // action[2:0], value[34:3], rank[45:35]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata   // value_out[31:0], rank_out[42:32], status[44:43]
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > 11) ? CW + 1 : 12;

    osm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, ptr_reg, ptr_next;
    logic [2:0]    act_reg;
    logic signed [31:0] val_reg;
    logic [10:0]   rank_reg;
    logic [31:0]   vout_reg, vout_next, hold_reg, hold_next;
    logic [10:0]   rout_reg, rout_next;
    logic [1:0]    st_reg, st_next;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic [CW-1:0] mid;
    logic [RW-1:0] rank_sum;
    logic          rank_ok;
    logic          go_right;
    logic          accept;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rank_sum = RW'(lo_reg) + RW'(1);
    assign rank_ok = (rank_reg >= 11'd1) && (RW'(rank_reg) <= RW'(count_reg));
    // insert and successor search "not above", others "below"
    assign go_right = (act_reg == osm_pkg::ACT_INSERT || act_reg == osm_pkg::ACT_SUCC)
        ? ($signed(rdata) <= val_reg) : ($signed(rdata) < val_reg);

    osm_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= osm_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        if (accept) begin
            act_reg  <= s_axis_tdata[2:0];
            val_reg  <= s_axis_tdata[34:3];
            rank_reg <= s_axis_tdata[45:35];
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        ptr_reg <= ptr_next;
        vout_reg <= vout_next;
        rout_reg <= rout_next;
        st_reg <= st_next;
        hold_reg <= hold_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            osm_pkg::S_IDLE:   if (accept) state_next = osm_pkg::S_DECIDE;
            osm_pkg::S_SRCH:   state_next = osm_pkg::S_SWAIT;
            osm_pkg::S_SWAIT:  state_next = osm_pkg::S_SDATA;
            osm_pkg::S_SDATA:  state_next = osm_pkg::S_DECIDE;
            osm_pkg::S_DECIDE: begin
                if (act_reg == osm_pkg::ACT_SELECT || act_reg > osm_pkg::ACT_SUCC) begin
                    state_next = (act_reg == osm_pkg::ACT_SELECT && rank_ok)
                        ? osm_pkg::S_FETCH : osm_pkg::S_OUT;
                end else if (act_reg == osm_pkg::ACT_INSERT && count_reg >= CW'(CAPACITY)) begin
                    state_next = osm_pkg::S_OUT;
                end else if (lo_reg < hi_reg) begin
                    state_next = osm_pkg::S_SRCH;
                end else begin
                    case (act_reg)
                        osm_pkg::ACT_INSERT: state_next = (lo_reg < count_reg)
                            ? osm_pkg::S_RD : osm_pkg::S_WR;
                        osm_pkg::ACT_REMOVE, osm_pkg::ACT_SUCC: state_next =
                            (lo_reg < count_reg) ? osm_pkg::S_FETCH : osm_pkg::S_OUT;
                        osm_pkg::ACT_PRED: state_next = (lo_reg != '0)
                            ? osm_pkg::S_FETCH : osm_pkg::S_OUT;
                        default: state_next = osm_pkg::S_OUT;
                    endcase
                end
            end
            osm_pkg::S_RD:    state_next = osm_pkg::S_RWAIT;
            osm_pkg::S_RWAIT: state_next = osm_pkg::S_WR;
            osm_pkg::S_WR: begin
                if (act_reg == osm_pkg::ACT_INSERT)
                    state_next = (ptr_reg == count_reg) ? osm_pkg::S_OUT : osm_pkg::S_RD;
                else
                    state_next = (ptr_reg + 1'b1 >= count_reg) ? osm_pkg::S_OUT : osm_pkg::S_RD;
            end
            osm_pkg::S_FETCH: state_next = osm_pkg::S_FWAIT;
            osm_pkg::S_FWAIT: state_next = osm_pkg::S_FDATA;
            osm_pkg::S_FDATA: begin
                if (act_reg == osm_pkg::ACT_REMOVE)
                    state_next = ($signed(rdata) != val_reg) ? osm_pkg::S_OUT
                        : ((ptr_reg + 1'b1 >= count_reg) ? osm_pkg::S_OUT : osm_pkg::S_RD);
                else
                    state_next = osm_pkg::S_OUT;
            end
            osm_pkg::S_OUT: if (m_axis_tready) state_next = osm_pkg::S_IDLE;
            default: state_next = osm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        ptr_next = ptr_reg;
        vout_next = vout_reg;
        rout_next = rout_reg;
        st_next = st_reg;
        hold_next = hold_reg;
        we = 1'b0;
        waddr = ptr_reg[AW-1:0];
        wdata = hold_reg;
        raddr = mid[AW-1:0];
        case (state_reg)
            osm_pkg::S_IDLE: begin
                lo_next = '0;
                hi_next = count_reg;
                vout_next = '0;
                rout_next = '0;
                st_next = osm_pkg::ST_DONE;
            end
            osm_pkg::S_SDATA: begin
                if (go_right) lo_next = mid + 1'b1;
                else hi_next = mid;
            end
            osm_pkg::S_DECIDE: begin
                ptr_next = lo_reg;
                hold_next = val_reg;
                if (act_reg == osm_pkg::ACT_SELECT) begin
                    ptr_next = CW'(rank_reg - 11'd1);
                    if (!rank_ok)
                        st_next = osm_pkg::ST_NONE;
                end else if (act_reg > osm_pkg::ACT_SUCC) begin
                    st_next = osm_pkg::ST_NONE;
                end else if (act_reg == osm_pkg::ACT_INSERT && count_reg >= CW'(CAPACITY)) begin
                    st_next = osm_pkg::ST_FULL;
                end else if (lo_reg >= hi_reg) begin
                    case (act_reg)
                        osm_pkg::ACT_REMOVE, osm_pkg::ACT_SUCC:
                            if (lo_reg >= count_reg) st_next = osm_pkg::ST_NONE;
                        osm_pkg::ACT_PRED: begin
                            ptr_next = lo_reg - 1'b1;
                            if (lo_reg == '0) st_next = osm_pkg::ST_NONE;
                        end
                        osm_pkg::ACT_RANK:
                            rout_next = (rank_sum > RW'(osm_pkg::RANK_MAX))
                                ? osm_pkg::RANK_MAX : rank_sum[10:0];
                        default: ;
                    endcase
                end
            end
            osm_pkg::S_RD, osm_pkg::S_RWAIT, osm_pkg::S_FETCH, osm_pkg::S_FWAIT: begin
                raddr = (state_reg == osm_pkg::S_RD || state_reg == osm_pkg::S_RWAIT)
                    && act_reg == osm_pkg::ACT_REMOVE
                    ? AW'(ptr_reg + 1'b1) : ptr_reg[AW-1:0];
            end
            osm_pkg::S_WR: begin
                we = 1'b1;
                if (act_reg == osm_pkg::ACT_INSERT) begin
                    // swap the carried value into place and advance
                    hold_next = rdata;
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == count_reg) count_next = count_reg + 1'b1;
                end else begin
                    wdata = rdata;
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg + 1'b1 >= count_reg) count_next = count_reg - 1'b1;
                end
            end
            osm_pkg::S_FDATA: begin
                if (act_reg == osm_pkg::ACT_REMOVE) begin
                    if ($signed(rdata) != val_reg) st_next = osm_pkg::ST_NONE;
                    else if (ptr_reg + 1'b1 >= count_reg) count_next = count_reg - 1'b1;
                end else begin
                    vout_next = rdata;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == osm_pkg::S_IDLE);
    assign m_axis_tvalid = (state_reg == osm_pkg::S_OUT);
    assign m_axis_tdata = {3'b000, st_reg, rout_reg, vout_reg};

    `CHK_IMPL(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY))
    `CHK_IMPL(a_excl, aclk, aresetn, 1'b1, !(s_axis_tready && m_axis_tvalid))
    `CHK_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CHK_NEXT(a_cnt_idle, aclk, aresetn, s_axis_tready && !s_axis_tvalid,
        $stable(count_reg))
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for order_statistic_multiset: directed table plus random operations,
// checked against a sorted-queue model of the multiset. Depends on osm_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int CAP = osm_pkg::CAPACITY_DEF;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic [1:0]         status;
        logic [10:0]        rank_out;
        logic signed [31:0] value_out;
    } answer_t;

    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] value;
        logic [10:0]        rank;
        bit                 typed;
        answer_t            ans;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int           errors = 0;
    int           idle_cycles = 0;
    bit           hold_off = 1'b0;
    logic signed [31:0] contents[$];
    answer_t      pending[$];
    row_t         directed[$];

    always #10 aclk = ~aclk;

    order_statistic_multiset dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic int count_below(logic signed [31:0] v);
        int n;
        n = 0;
        foreach (contents[i]) if (contents[i] < v) n++;
        return n;
    endfunction

    function automatic int count_not_above(logic signed [31:0] v);
        int n;
        n = 0;
        foreach (contents[i]) if (contents[i] <= v) n++;
        return n;
    endfunction

    function automatic answer_t apply_op(logic [2:0] act, logic signed [31:0] v,
                                         logic [10:0] r);
        answer_t a;
        int p;
        a = '{value_out: '0, rank_out: '0, status: osm_pkg::ST_DONE};
        case (act)
            osm_pkg::ACT_INSERT: begin
                if (contents.size() >= CAP) a.status = osm_pkg::ST_FULL;
                else contents.insert(count_not_above(v), v);
            end
            osm_pkg::ACT_REMOVE: begin
                p = count_below(v);
                if (p < contents.size() && contents[p] == v) contents.delete(p);
                else a.status = osm_pkg::ST_NONE;
            end
            osm_pkg::ACT_RANK: begin
                p = count_below(v) + 1;
                a.rank_out = (p > osm_pkg::RANK_MAX) ? osm_pkg::RANK_MAX : 11'(p);
            end
            osm_pkg::ACT_SELECT: begin
                if (r >= 1 && r <= contents.size()) a.value_out = contents[r - 1];
                else a.status = osm_pkg::ST_NONE;
            end
            osm_pkg::ACT_PRED: begin
                p = count_below(v);
                if (p > 0) a.value_out = contents[p - 1];
                else a.status = osm_pkg::ST_NONE;
            end
            osm_pkg::ACT_SUCC: begin
                p = count_not_above(v);
                if (p < contents.size()) a.value_out = contents[p];
                else a.status = osm_pkg::ST_NONE;
            end
            default: a.status = osm_pkg::ST_NONE;
        endcase
        return a;
    endfunction

    task automatic send_request(logic [2:0] act, logic signed [31:0] v, logic [10:0] r,
                                bit typed, answer_t typed_ans);
        answer_t a;
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap + 1) @(posedge aclk);
        a = apply_op(act, v, r);
        if (typed && a !== typed_ans) begin
            $error("directed row: expected %h, model gives %h", typed_ans, a);
            errors++;
        end
        pending.push_back(a);
        s_axis_tdata <= {2'b00, r, v, act};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    task automatic random_request(int fill_bias);
        logic [2:0] act;
        logic [10:0] r;
        int k;
        k = $urandom_range(0, 99);
        if (k < fill_bias) act = osm_pkg::ACT_INSERT;
        else if (k < 98) act = 3'($urandom_range(1, 5));
        else act = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 7) == 0) r = 11'($urandom);
        else r = 11'($urandom_range(0, contents.size() + 2));
        send_request(act, pick_value(), r, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        answer_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[44:0];
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
                    errors++;
                end
                if (got.rank_out !== want.rank_out) begin
                    $error("rank_out: expected %0d, got %0d", want.rank_out, got.rank_out);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        int w;
        forever begin
            @(posedge aclk);
            if (hold_off || (m_axis_tvalid && m_axis_tready)) begin
                m_axis_tready <= 1'b0;
                if (!hold_off) begin
                    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    repeat (w) @(posedge aclk);
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic row_t mk(logic [2:0] act, logic signed [31:0] v, logic [10:0] r,
                                bit typed, logic signed [31:0] vo, logic [10:0] ro,
                                logic [1:0] st);
        row_t x;
        x.act = act; x.value = v; x.rank = r; x.typed = typed;
        x.ans = '{value_out: vo, rank_out: ro, status: st};
        return x;
    endfunction

    initial begin
        directed = '{
            mk(osm_pkg::ACT_SELECT, 0, 1, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_PRED, 32'sh7fffffff, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_SUCC, 32'sh80000000, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_REMOVE, 5, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_RANK, 32'sh7fffffff, 0, 1, 0, 1, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_INSERT, 32'sh80000000, 0, 1, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_INSERT, 32'sh7fffffff, 0, 1, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_INSERT, 7, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_INSERT, 7, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_RANK, 7, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_RANK, 8, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_SELECT, 0, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_SELECT, 0, 4, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_SELECT, 0, 5, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_SELECT, 0, 11'h7ff, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_PRED, 32'sh80000000, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_SUCC, 32'sh7fffffff, 0, 1, 0, 0, osm_pkg::ST_NONE),
            mk(osm_pkg::ACT_PRED, 32'sh7fffffff, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_SUCC, 32'sh80000000, 0, 0, 0, 0, osm_pkg::ST_DONE),
            mk(osm_pkg::ACT_REMOVE, 7, 0, 1, 0, 0, osm_pkg::ST_DONE),
            mk(3'd6, 32'shffffffff, 11'h7ff, 1, 0, 0, osm_pkg::ST_NONE),
            mk(3'd7, 0, 0, 1, 0, 0, osm_pkg::ST_NONE)
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i])
            send_request(directed[i].act, directed[i].value, directed[i].rank,
                         directed[i].typed, directed[i].ans);
        for (int i = 0; i < 200; i++) random_request(45);
        // stall the result side while requests keep coming
        hold_off = 1'b1;
        fork
            begin repeat (300) @(posedge aclk); hold_off = 1'b0; end
            for (int i = 0; i < 5; i++) random_request(45);
        join
        // pause until the block has drained
        while (pending.size() != 0) @(posedge aclk);
        // fill to capacity to reach the full-store path
        while (contents.size() < CAP)
            send_request(osm_pkg::ACT_INSERT, $urandom, 0, 1'b0, '0);
        for (int i = 0; i < 20; i++) random_request(70);
        for (int i = 0; i < 100; i++) random_request(10);
        for (int i = 0; i < 100 && contents.size() > 0; i++)
            send_request(osm_pkg::ACT_REMOVE,
                         contents[$urandom_range(0, contents.size() - 1)],
                         0, 1'b0, '0);
        for (int i = 0; i < 100; i++) random_request(40);
        while (pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
